FILE: hdl/stbs_pkg.sv
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths fixed by the item format
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  // Search bounds carry a sign bit and one bit of headroom (hi can reach -1, lo can reach 1024)
  localparam int BND_W  = IDX_W + 2;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXACT = 2'd1;
  localparam logic [1:0] OP_LOWER = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [IDX_W-1:0]         write_index;
    logic signed [DATA_W-1:0] key_or_data;
    logic [IDX_W-1:0]         range_low;
    logic [IDX_W-1:0]         range_high;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_t;

  // Write request from the sequencer to the table
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] data;
  } wr_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

FILE: hdl/stbs_table.sv
module stbs_table (
  input  logic                             clk,
  input  stbs_pkg::wr_req_t                wr,
  input  logic [stbs_pkg::IDX_W-1:0]       rd_idx,
  output logic signed [stbs_pkg::DATA_W-1:0] rd_data
);
  import stbs_pkg::*;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_q;
  logic                     rd_ok;
  logic                     wr_ok;
  logic                     rd_in_range;

  // Indexes past the table: writes dropped, reads give zero
  assign wr_ok       = 32'(wr.idx) < 32'(TABLE_DEPTH);
  assign rd_in_range = 32'(rd_idx) < 32'(TABLE_DEPTH);

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr.en && wr_ok) begin
      mem[ADDR_W'(wr.idx)] <= wr.data;
    end
    rd_q  <= mem[ADDR_W'(rd_idx)];
    rd_ok <= rd_in_range;
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

FILE: hdl/stbs_ctrl.sv
module stbs_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  stbs_pkg::in_t                    in_item,
  output stbs_pkg::wr_req_t                wr,
  output logic [stbs_pkg::IDX_W-1:0]       rd_idx,
  input  logic signed [stbs_pkg::DATA_W-1:0] rd_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output stbs_pkg::out_t                   res
);
  import stbs_pkg::*;

  state_t state, state_next;

  logic signed [BND_W-1:0]  lo, lo_next;
  logic signed [BND_W-1:0]  hi, hi_next;
  logic signed [DATA_W-1:0] key, key_next;
  logic                     lower, lower_next;   // lower-bound mode
  logic                     first, first_next;   // lower-bound top-of-range probe pending
  logic [IDX_W-1:0]         pidx, pidx_next;     // index probed last
  logic                     found, found_next;
  logic [IDX_W-1:0]         pos, pos_next;

  logic [BND_W:0]           bsum;
  logic [IDX_W-1:0]         mid;
  logic signed [BND_W-1:0]  pidx_s;
  logic signed [BND_W-1:0]  lo_new, hi_new;
  logic                     eq, lt;

  // Midpoint; both bounds are non-negative whenever a probe is issued
  assign bsum   = {lo[BND_W-1], lo} + {hi[BND_W-1], hi};
  assign mid    = bsum[IDX_W:1];
  assign pidx_s = $signed({2'b00, pidx});

  // Shared compare of the probed entry against the key
  assign eq = (rd_data == key);
  assign lt = (rd_data < key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    key   <= key_next;
    lower <= lower_next;
    first <= first_next;
    pidx  <= pidx_next;
    found <= found_next;
    pos   <= pos_next;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    key_next   = key;
    lower_next = lower;
    first_next = first;
    pidx_next  = pidx;
    found_next = found;
    pos_next   = pos;
    lo_new     = lo;
    hi_new     = hi;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    wr.en      = 1'b0;
    wr.idx     = in_item.write_index;
    wr.data    = in_item.key_or_data;
    rd_idx     = mid;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          found_next = 1'b0;
          pos_next   = '0;
          lo_next    = $signed({2'b00, in_item.range_low});
          hi_next    = $signed({2'b00, in_item.range_high});
          key_next   = in_item.key_or_data;
          lower_next = (in_item.opcode == OP_LOWER);
          first_next = 1'b1;
          case (in_item.opcode)
            OP_WRITE: begin
              wr.en      = 1'b1;
              state_next = S_DONE;
            end
            OP_EXACT, OP_LOWER: begin
              // Empty range finishes at once
              if (in_item.range_low > in_item.range_high) begin
                state_next = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Present the probe address; data is back next cycle
      S_READ: begin
        rd_idx     = (lower && first) ? hi[IDX_W-1:0] : mid;
        pidx_next  = rd_idx;
        state_next = S_CHECK;
      end

      S_CHECK: begin
        if (!lower) begin
          // Exact match
          if (eq) begin
            found_next = 1'b1;
            pos_next   = pidx;
            state_next = S_DONE;
          end else begin
            if (lt) begin
              lo_new = pidx_s + BND_W'(1);
            end else begin
              hi_new = pidx_s - BND_W'(1);
            end
            lo_next = lo_new;
            hi_next = hi_new;
            state_next = (lo_new > hi_new) ? S_DONE : S_READ;
          end
        end else if (first) begin
          // Top-of-range probe: key above the last entry of the range means not found
          first_next = 1'b0;
          if (lt) begin
            state_next = S_DONE;
          end else if (lo == hi) begin
            found_next = 1'b1;
            pos_next   = lo[IDX_W-1:0];
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end else begin
          // Lower bound narrowing
          if (lt) begin
            lo_new = pidx_s + BND_W'(1);
          end else begin
            hi_new = pidx_s;
          end
          lo_next = lo_new;
          hi_next = hi_new;
          if (lo_new == hi_new) begin
            found_next = 1'b1;
            pos_next   = lo_new[IDX_W-1:0];
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.found    = found;
  assign res.position = pos;

endmodule

FILE: hdl/sorted_table_binary_search.sv
// Channel | Signals                           | Payload
// --------+-----------------------------------+------------------------------
// input   | in_valid, in_ready, in_data       | opcode, write_index, key_or_data,
//         |                                   | range_low, range_high
// output  | out_valid, out_ready, out_data    | found, position
//
// One item at a time. A write or an unused opcode goes straight from idle to done;
// a search runs a read state and a check state for each table probe. Each probe
// is a registered memory read followed by one compare. Reset (rst, synchronous)
// returns the sequencer to idle; the table contents are undefined until written.
// A finished result moves to the output register, so a stalled output holds only
// the next item's last step.
module sorted_table_binary_search (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  stbs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output stbs_pkg::out_t out_data
);
  import stbs_pkg::*;

  wr_req_t                  wr;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [DATA_W-1:0] rd_data;
  logic                     res_valid;
  logic                     res_ready;
  out_t                     res;

  stbs_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_data),
    .wr        (wr),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register; loads when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

endmodule

FILE: verif/tb_top.sv
import stbs_pkg::*;

// Tracks the table contents and the queue of expected search results
class search_scoreboard;
  logic signed [DATA_W-1:0] entry_copy [TABLE_DEPTH];
  bit                       written [TABLE_DEPTH];
  out_t                     expected_results [$];
  int                       errors;

  function new();
    errors = 0;
    foreach (entry_copy[i]) begin
      entry_copy[i] = '0;
      written[i]    = 1'b0;
    end
  endfunction

  // Expected result of one item; reads_ok drops if any probe hits an unwritten entry
  function out_t predict(in_t it, output bit reads_ok);
    int lo, hi, mid;
    bit done;
    logic signed [DATA_W-1:0] key, v;
    out_t r;
    r        = '0;
    reads_ok = 1'b1;
    done     = 1'b0;
    lo       = int'(it.range_low);
    hi       = int'(it.range_high);
    key      = it.key_or_data;
    case (it.opcode)
      OP_EXACT: begin
        while (!done && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (!written[mid]) reads_ok = 1'b0;
          v = entry_copy[mid];
          if (v == key) begin
            r.found    = 1'b1;
            r.position = mid[IDX_W-1:0];
            done       = 1'b1;
          end else if (v > key) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      OP_LOWER: begin
        // Last entry is probed first: smaller than the key means no match
        if (lo <= hi) begin
          if (!written[hi]) reads_ok = 1'b0;
          if (!(entry_copy[hi] < key)) begin
            while (lo != hi) begin
              mid = (lo + hi) / 2;
              if (!written[mid]) reads_ok = 1'b0;
              if (entry_copy[mid] < key) lo = mid + 1;
              else hi = mid;
            end
            r.found    = 1'b1;
            r.position = lo[IDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Accepted input transfer: queue its result, then apply any table write
  function void note_input(in_t it);
    bit ok;
    expected_results = {expected_results, predict(it, ok)};
    if (it.opcode == OP_WRITE) begin
      entry_copy[it.write_index] = it.key_or_data;
      written[it.write_index]    = 1'b1;
    end
  endfunction

  function void check_result(out_t got);
    out_t exp;
    if (expected_results.size() == 0) begin
      $error("unexpected result: found %0d, position %0d", got.found, got.position);
      errors++;
    end else begin
      exp = expected_results.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, actual %0d", exp.found, got.found);
        errors++;
      end
      if (got.position !== exp.position) begin
        $error("position: expected %0d, actual %0d", exp.position, got.position);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fffffff;
  localparam int RANDOM_ITEMS = 1450;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int last_base      = 0;
  int last_len       = 1;

  search_scoreboard sb;

  sorted_table_binary_search dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: random back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result transfers
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Optional idle gap, then hold the item until the input transfer happens
  task automatic send_item(input in_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic write_entry(input int idx, input logic signed [DATA_W-1:0] value);
    in_t it;
    it.opcode      = OP_WRITE;
    it.write_index = idx[IDX_W-1:0];
    it.key_or_data = value;
    it.range_low   = IDX_W'($urandom_range(1023));
    it.range_high  = IDX_W'($urandom_range(1023));
    send_item(it);
  endtask

  // Search that would probe unwritten entries is turned into an empty range
  task automatic search_or_empty(input logic [1:0] op, input int lo, input int hi,
                                 input logic signed [DATA_W-1:0] key);
    in_t it;
    bit  ok;
    out_t unused;
    it.opcode      = op;
    it.write_index = IDX_W'($urandom_range(1023));
    it.key_or_data = key;
    it.range_low   = lo[IDX_W-1:0];
    it.range_high  = hi[IDX_W-1:0];
    unused = sb.predict(it, ok);
    if (!ok) begin
      it.range_low  = 10'd1023;
      it.range_high = IDX_W'($urandom_range(1022));
    end
    send_item(it);
  endtask

  // Key near the entries of [lo, hi]: hits, neighbors, below, above, random, extremes
  function automatic logic signed [DATA_W-1:0] pick_key(input int lo, input int hi);
    int sel, idx;
    logic signed [DATA_W-1:0] v;
    if (lo > hi) return $urandom;
    idx = $urandom_range(hi, lo);
    v   = sb.entry_copy[idx];
    sel = $urandom_range(9);
    case (sel)
      4:       return v + 1;
      5:       return v - 1;
      6:       return sb.entry_copy[lo] - 1;
      7:       return sb.entry_copy[hi] + 1;
      8:       return $urandom;
      9:       return $urandom_range(1) ? INT_MIN : INT_MAX;
      default: return v;
    endcase
  endfunction

  // Non-decreasing run of writes over a region, then searches inside it
  task automatic fill_region();
    int base, len, mode, n, lo, hi, t;
    longint cur, step;
    base = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 0 : 1023 - $urandom_range(40))
                                    : $urandom_range(1023);
    len  = ($urandom_range(4) == 0) ? $urandom_range(160, 1) : $urandom_range(40, 1);
    if (base + len > TABLE_DEPTH) len = TABLE_DEPTH - base;
    mode = $urandom_range(2);
    if ($urandom_range(7) == 0) cur = INT_MIN;
    else if ($urandom_range(1)) cur = longint'(int'($urandom));
    else cur = longint'($urandom_range(2000)) - 1000;
    for (int i = 0; i < len; i++) begin
      write_entry(base + i, cur[DATA_W-1:0]);
      case (mode)
        0:       step = longint'($urandom_range(1));
        1:       step = longint'($urandom_range(1000, 1));
        default: step = longint'($urandom_range(1 << 24, 1));
      endcase
      cur += step;
      if (cur > INT_MAX) cur = INT_MAX;
    end
    last_base = base;
    last_len  = len;
    n = $urandom_range(16, 4);
    for (int k = 0; k < n; k++) begin
      lo = base + $urandom_range(len - 1);
      hi = lo + $urandom_range(base + len - 1 - lo);
      if ($urandom_range(9) == 0) begin
        t = lo; lo = hi; hi = t;
      end
      search_or_empty($urandom_range(1) ? OP_EXACT : OP_LOWER, lo, hi, pick_key(lo, hi));
    end
  endtask

  // Searches in the latest region or anywhere in the table
  task automatic search_burst();
    int n, lo, hi;
    n = $urandom_range(8, 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1)) begin
        lo = last_base + $urandom_range(last_len - 1);
        hi = lo + $urandom_range(last_base + last_len - 1 - lo);
      end else begin
        lo = $urandom_range(1023);
        hi = lo + $urandom_range(1023 - lo);
      end
      search_or_empty($urandom_range(1) ? OP_EXACT : OP_LOWER, lo, hi, pick_key(lo, hi));
    end
  endtask

  // Unused opcode, stray writes, empty and random ranges
  task automatic noise_item();
    in_t it;
    int  lo;
    case ($urandom_range(3))
      0: begin
        it.opcode      = OP_UNUSED;
        it.write_index = IDX_W'($urandom_range(1023));
        it.key_or_data = $urandom;
        it.range_low   = IDX_W'($urandom_range(1023));
        it.range_high  = IDX_W'($urandom_range(1023));
        send_item(it);
      end
      1: write_entry($urandom_range(1023), $urandom);
      2: begin
        lo = $urandom_range(1023, 1);
        search_or_empty($urandom_range(1) ? OP_EXACT : OP_LOWER, lo,
                        $urandom_range(lo - 1), $urandom);
      end
      default: begin
        lo = $urandom_range(1023);
        search_or_empty($urandom_range(1) ? OP_EXACT : OP_LOWER, lo,
                        $urandom_range(1023), $urandom);
      end
    endcase
  endtask

  // Run watchdog
  initial begin
    #4ms;
    $display("[sorted_table_binary_search] ERROR");
    $finish;
  end

  initial begin
    in_t it;
    int  target;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: table ends hold the data extremes, with a duplicate pair
    write_entry(0, INT_MIN);
    write_entry(1, -100);
    write_entry(2, -1);
    write_entry(3, 0);
    write_entry(4, 5);
    write_entry(5, 5);
    write_entry(1018, 100);
    write_entry(1019, 200);
    write_entry(1020, 300);
    write_entry(1021, 400);
    write_entry(1022, INT_MAX - 1);
    write_entry(1023, INT_MAX);
    search_or_empty(OP_EXACT, 0, 5, INT_MIN);
    search_or_empty(OP_EXACT, 1018, 1023, INT_MAX);
    search_or_empty(OP_EXACT, 0, 5, 1);
    search_or_empty(OP_LOWER, 0, 5, 5);
    search_or_empty(OP_LOWER, 0, 5, 6);
    search_or_empty(OP_LOWER, 0, 5, INT_MIN);
    search_or_empty(OP_LOWER, 1018, 1023, 250);
    search_or_empty(OP_EXACT, 3, 3, 0);
    search_or_empty(OP_LOWER, 1023, 0, 7);
    search_or_empty(OP_EXACT, 1023, 0, 7);
    search_or_empty(OP_LOWER, 1023, 1023, INT_MAX);
    it = '1;
    it.opcode = OP_UNUSED;
    send_item(it);

    // Random part in four idling phases
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      case ((items_sent / 300) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: fill_region();
        7, 8, 9, 10, 11, 12, 13, 14, 15: search_burst();
        default: noise_item();
      endcase
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then keep watching for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[sorted_table_binary_search] OK");
    end else begin
      $display("[sorted_table_binary_search] ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/stbs_pkg.sv
hdl/stbs_table.sv
hdl/stbs_ctrl.sv
hdl/sorted_table_binary_search.sv
verif/tb_top.sv
